[src/wheel_speed_pid_assert.svh]
// ----------------------------------------------------------------------------
// Wheel speed PID assertion macros
// Clocked assertion helpers, quiet while reset is asserted. Empty when the
// SYNTHESIS macro is set.
// ----------------------------------------------------------------------------
`ifndef WHEEL_SPEED_PID_ASSERT_SVH
`define WHEEL_SPEED_PID_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property at every rising clock edge outside reset
`define WSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition in one cycle leads to a condition in the next
`define WSP_ASSERT_NEXT(lbl, pre, post, msg) \
  `WSP_ASSERT(lbl, (pre) |=> (post), msg)

`else

`define WSP_ASSERT(lbl, prop, msg)
`define WSP_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

[src/wsp_pkg.sv]
// ----------------------------------------------------------------------------
// Wheel speed PID package
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package wsp_pkg;

  // Field widths
  localparam int unsigned SpeedW  = 13;
  localparam int unsigned ErrW    = SpeedW + 1;
  localparam int unsigned GainW   = 10;
  localparam int unsigned LimitW  = 15;
  localparam int unsigned AccW    = 16;
  localparam int unsigned CfgIdxW = 3;

  // Stream widths
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = AccW;

  // Reset values of the configuration registers
  localparam logic [GainW-1:0]  KpReset   = GainW'(100);
  localparam logic [GainW-1:0]  KiReset   = GainW'(30);
  localparam logic [GainW-1:0]  KdReset   = GainW'(4);
  localparam logic [LimitW-1:0] ILimReset = LimitW'(8700);
  localparam logic [LimitW-1:0] OLimReset = LimitW'(8700);

  // Saturation bounds of the P/D accumulator
  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_KP   = 3'd0,
    REG_KI   = 3'd1,
    REG_KD   = 3'd2,
    REG_ILIM = 3'd3,
    REG_OLIM = 3'd4
  } reg_idx_e;

  // Gains and limits as seen by the datapath
  typedef struct packed {
    logic [GainW-1:0]  kp;
    logic [GainW-1:0]  ki;
    logic [GainW-1:0]  kd;
    logic [LimitW-1:0] ilim;
    logic [LimitW-1:0] olim;
  } cfg_t;

  // Loop state carried from one tick to the next
  typedef struct packed {
    logic signed [ErrW-1:0] err_prev;
    logic signed [ErrW-1:0] err_prev2;
    logic signed [AccW-1:0] int_acc;
    logic signed [AccW-1:0] pd_acc;
  } state_t;

endpackage

`default_nettype wire

[src/wsp_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Wheel speed PID configuration registers
// Holds gains and limits; one register written per transfer, unknown
// indexes dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [wsp_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [wsp_pkg::LimitW-1:0]      cfg_data_i,
  output wsp_pkg::cfg_t                        cfg_o
);

  wsp_pkg::cfg_t cfg_q, cfg_d;

  // Always take a write
  assign cfg_ready_o = 1'b1;

  // Decode the register index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (wsp_pkg::reg_idx_e'(cfg_index_i))
        wsp_pkg::REG_KP:   cfg_d.kp   = cfg_data_i[wsp_pkg::GainW-1:0];
        wsp_pkg::REG_KI:   cfg_d.ki   = cfg_data_i[wsp_pkg::GainW-1:0];
        wsp_pkg::REG_KD:   cfg_d.kd   = cfg_data_i[wsp_pkg::GainW-1:0];
        wsp_pkg::REG_ILIM: cfg_d.ilim = cfg_data_i;
        wsp_pkg::REG_OLIM: cfg_d.olim = cfg_data_i;
        default:           cfg_d      = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp   <= wsp_pkg::KpReset;
      cfg_q.ki   <= wsp_pkg::KiReset;
      cfg_q.kd   <= wsp_pkg::KdReset;
      cfg_q.ilim <= wsp_pkg::ILimReset;
      cfg_q.olim <= wsp_pkg::OLimReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[src/wsp_pid_calc.sv]
// ----------------------------------------------------------------------------
// Wheel speed PID update
// Forms the error differences, both accumulators with their clamps, the
// duty command and the next loop state for one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_pid_calc (
  input  wire logic signed [wsp_pkg::ErrW-1:0] err_i,
  input  wire logic                            clr_i,
  input  wsp_pkg::cfg_t                        cfg_i,
  input  wsp_pkg::state_t                      state_i,
  output wsp_pkg::state_t                      state_o,
  output logic signed [wsp_pkg::AccW-1:0]      duty_o
);

  localparam int unsigned D1W   = wsp_pkg::ErrW + 2;
  localparam int unsigned D2W   = wsp_pkg::ErrW + 3;
  localparam int unsigned PdW   = 28;
  localparam int unsigned IntW  = 25;
  localparam int unsigned DutyW = wsp_pkg::AccW + 1;

  logic signed [D1W-1:0]   d1;
  logic signed [D2W-1:0]   d2;
  logic signed [PdW-1:0]   kp_x, kd_x, d1_x, d2_x, pd_sum;
  logic signed [IntW-1:0]  ki_x, e_x, int_sum, ilim_x;
  logic signed [wsp_pkg::AccW-1:0] int_new, pd_new;
  logic signed [DutyW-1:0] duty_sum, olim_x;

  // First and second differences of the error
  assign d1 = D1W'(err_i) - D1W'(state_i.err_prev);
  assign d2 = D2W'(err_i) - (D2W'(state_i.err_prev) <<< 1) + D2W'(state_i.err_prev2);

  // P/D accumulator, saturated to the 16-bit range
  assign kp_x   = PdW'($signed({1'b0, cfg_i.kp}));
  assign kd_x   = PdW'($signed({1'b0, cfg_i.kd}));
  assign d1_x   = PdW'(d1);
  assign d2_x   = PdW'(d2);
  assign pd_sum = PdW'(state_i.pd_acc) + kp_x * d1_x + kd_x * d2_x;

  always_comb begin
    if (pd_sum > PdW'(wsp_pkg::AccMax)) begin
      pd_new = wsp_pkg::AccMax;
    end else if (pd_sum < PdW'(wsp_pkg::AccMin)) begin
      pd_new = wsp_pkg::AccMin;
    end else begin
      pd_new = pd_sum[wsp_pkg::AccW-1:0];
    end
  end

  // Integral accumulator, clamped to the integral limit
  assign ki_x    = IntW'($signed({1'b0, cfg_i.ki}));
  assign e_x     = IntW'(err_i);
  assign ilim_x  = IntW'($signed({1'b0, cfg_i.ilim}));
  assign int_sum = IntW'(state_i.int_acc) + ki_x * e_x;

  always_comb begin
    if (int_sum > ilim_x) begin
      int_new = ilim_x[wsp_pkg::AccW-1:0];
    end else if (int_sum < -ilim_x) begin
      int_new = wsp_pkg::AccW'(-ilim_x);
    end else begin
      int_new = int_sum[wsp_pkg::AccW-1:0];
    end
  end

  // Duty command, clamped to the output limit
  assign olim_x   = DutyW'($signed({1'b0, cfg_i.olim}));
  assign duty_sum = DutyW'(int_new) + DutyW'(pd_new);

  always_comb begin
    if (duty_sum > olim_x) begin
      duty_o = olim_x[wsp_pkg::AccW-1:0];
    end else if (duty_sum < -olim_x) begin
      duty_o = wsp_pkg::AccW'(-olim_x);
    end else begin
      duty_o = duty_sum[wsp_pkg::AccW-1:0];
    end
  end

  // Shift the error history and apply the clear after the update
  always_comb begin
    state_o.err_prev  = err_i;
    state_o.err_prev2 = state_i.err_prev;
    state_o.int_acc   = clr_i ? '0 : int_new;
    state_o.pd_acc    = pd_new;
  end

endmodule

`default_nettype wire

[src/wheel_speed_pid.sv]
// ----------------------------------------------------------------------------
// Wheel speed PID: input register (error, clear), output register (duty). One
// tick per cycle unless the output stalls; loop state updates as a tick leaves
// the input register. Reset restores default gains/limits, zeroes loop state.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wheel_speed_pid_assert.svh"

module wheel_speed_pid (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [wsp_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [wsp_pkg::LimitW-1:0]        cfg_data_i,
  // Input ticks
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: [12:0] target_speed, [25:13] measured_speed, [31:26] zero
  input  wire logic [wsp_pkg::InDataW-1:0]       s_axis_tdata,
  // tuser: [0] clear_integral
  input  wire logic                              s_axis_tuser,
  // Duty results
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // tdata: [15:0] duty
  output logic [wsp_pkg::OutDataW-1:0]           m_axis_tdata
);

  localparam int unsigned SW = wsp_pkg::SpeedW;
  localparam int unsigned EW = wsp_pkg::ErrW;

  wsp_pkg::cfg_t   cfg;
  wsp_pkg::state_t state_q, state_d;

  logic signed [SW-1:0] tgt, meas;
  logic signed [EW-1:0] err_in, err_q;
  logic                 clr_q;
  logic                 in_valid_q;
  logic                 out_valid_q;
  logic signed [wsp_pkg::AccW-1:0] duty_d, duty_q;
  logic                 in_xfer, advance;

  wsp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Handshake: move a tick on whenever the output register is free or drains
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Form the error on the way into the input register
  assign tgt    = s_axis_tdata[SW-1:0];
  assign meas   = s_axis_tdata[2*SW-1:SW];
  assign err_in = EW'(tgt) - EW'(meas);

  wsp_pid_calc u_calc (
    .err_i   (err_q),
    .clr_i   (clr_q),
    .cfg_i   (cfg),
    .state_i (state_q),
    .state_o (state_d),
    .duty_o  (duty_d)
  );

  // Valid flags and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      err_q <= err_in;
      clr_q <= s_axis_tuser;
    end
    if (advance) begin
      duty_q <= duty_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = duty_q;

  // Checks on the pipeline and the loop state
  `WSP_ASSERT_NEXT(a_in_hold, in_valid_q && !advance, in_valid_q && $stable(err_q), "input register lost a stalled tick")
  `WSP_ASSERT_NEXT(a_hist_shift, advance, (state_q.err_prev == $past(err_q)) && (state_q.err_prev2 == $past(state_q.err_prev)), "error history did not shift")
  `WSP_ASSERT_NEXT(a_clear, advance && clr_q, state_q.int_acc == '0, "integral not cleared")
  `WSP_ASSERT_NEXT(a_state_hold, !advance, $stable(state_q), "loop state changed without a tick")

endmodule

`default_nettype wire

[tb/wsp_duty_checker.sv]
// ----------------------------------------------------------------------------
// Wheel speed PID duty checker
// Watches the configuration, tick and duty channels of the PID block. Keeps
// its own copy of the gains, limits and loop state, predicts the duty of every
// accepted tick and compares each duty transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module wsp_duty_checker
  import wsp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [LimitW-1:0]   cfg_data_i,
  // Tick channel
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  // tdata: [12:0] target_speed, [25:13] measured_speed, [31:26] zero
  input  logic [InDataW-1:0]  s_tdata_i,
  // tuser: [0] clear_integral
  input  logic                s_tuser_i,
  // Duty channel
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  // tdata: [15:0] duty
  input  logic [OutDataW-1:0] m_tdata_i,
  // Status for the stimulus side
  output int unsigned         mismatches_o,
  output int unsigned         duty_pending_o,
  output int unsigned         duty_seen_o
);

  // Gains and limits as the block should hold them
  int kp_gain;
  int ki_gain;
  int kd_gain;
  int int_limit;
  int out_limit;

  // Loop state
  int err_prev;
  int err_prev2;
  int int_acc;
  int pd_acc;

  logic [OutDataW-1:0] pending_duty_q[$];

  function automatic int clip(input int v, input int lo, input int hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Advance the loop by one tick and return the duty it commands
  function automatic logic [OutDataW-1:0] next_duty(input int tgt, input int meas,
                                                    input bit clr);
    int err;
    int d1;
    int d2;
    int i_new;
    int pd_new;
    int duty;
    err    = tgt - meas;
    d1     = err - err_prev;
    d2     = err - 2 * err_prev + err_prev2;
    i_new  = clip(int_acc + ki_gain * err, -int_limit, int_limit);
    pd_new = clip(pd_acc + kp_gain * d1 + kd_gain * d2, int'(AccMin), int'(AccMax));
    duty   = clip(i_new + pd_new, -out_limit, out_limit);
    // The duty of this tick still sees the integral from before a clear
    int_acc   = clr ? 0 : i_new;
    pd_acc    = pd_new;
    err_prev2 = err_prev;
    err_prev  = err;
    return OutDataW'(duty);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [OutDataW-1:0] want;
    if (!rst_ni) begin
      kp_gain   = int'(KpReset);
      ki_gain   = int'(KiReset);
      kd_gain   = int'(KdReset);
      int_limit = int'(ILimReset);
      out_limit = int'(OLimReset);
      err_prev  = 0;
      err_prev2 = 0;
      int_acc   = 0;
      pd_acc    = 0;
      pending_duty_q.delete();
      mismatches_o   = 0;
      duty_pending_o = 0;
      duty_seen_o    = 0;
    end else begin
      // Register writes; indexes past the last register are dropped
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_KP:   kp_gain   = int'(cfg_data_i[GainW-1:0]);
          REG_KI:   ki_gain   = int'(cfg_data_i[GainW-1:0]);
          REG_KD:   kd_gain   = int'(cfg_data_i[GainW-1:0]);
          REG_ILIM: int_limit = int'(cfg_data_i);
          REG_OLIM: out_limit = int'(cfg_data_i);
          default: ;
        endcase
      end

      // Compare each duty transfer with the oldest prediction
      if (m_tvalid_i && m_tready_i) begin
        duty_seen_o++;
        if (pending_duty_q.size() == 0) begin
          mismatches_o++;
          $display("%0t: duty %0d arrived with no tick outstanding", $time,
                   $signed(m_tdata_i));
        end else begin
          want = pending_duty_q.pop_front();
          if (m_tdata_i !== want) begin
            mismatches_o++;
            $display("%0t: duty mismatch, expected %0d, got %0d", $time,
                     $signed(want), $signed(m_tdata_i));
          end
        end
      end

      // Predict the duty of each accepted tick
      if (s_tvalid_i && s_tready_i) begin
        pending_duty_q.push_back(next_duty($signed(s_tdata_i[SpeedW-1:0]),
                                           $signed(s_tdata_i[2*SpeedW-1:SpeedW]),
                                           s_tuser_i));
      end
      duty_pending_o = pending_duty_q.size();
    end
  end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Wheel speed PID testbench
// Drives control ticks and register writes into the PID block with random
// gaps and output stalls: a short directed part at the field extremes, then
// random phases under changing gains and limits. A separate checker predicts
// every duty; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import wsp_pkg::*;

  localparam int HalfPeriod    = 6;
  localparam int TimeoutLimit  = 3_000_000;
  localparam int OutputLatency = 2;
  localparam int Phases        = 6;
  localparam int PhaseTicks    = 100;
  localparam int SpeedMax      = (1 << (SpeedW - 1)) - 1;
  localparam int SpeedMin      = -(1 << (SpeedW - 1));
  localparam int GainMax       = (1 << GainW) - 1;
  localparam int LimitMax      = (1 << LimitW) - 1;
  localparam int CfgIdxMax     = (1 << CfgIdxW) - 1;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [LimitW-1:0]   cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b1;
  logic [OutDataW-1:0] m_axis_tdata;

  int unsigned mismatches;
  int unsigned duty_pending;
  int unsigned duty_seen;

  bit gaps_on = 1'b1;
  int ticks_sent;
  int clears_sent;
  int reg_writes;
  int settings_used;
  int tgt_walk;
  int meas_walk;

  wheel_speed_pid dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  wsp_duty_checker chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_tvalid_i     (s_axis_tvalid),
    .s_tready_i     (s_axis_tready),
    .s_tdata_i      (s_axis_tdata),
    .s_tuser_i      (s_axis_tuser),
    .m_tvalid_i     (m_axis_tvalid),
    .m_tready_i     (m_axis_tready),
    .m_tdata_i      (m_axis_tdata),
    .mismatches_o   (mismatches),
    .duty_pending_o (duty_pending),
    .duty_seen_o    (duty_seen)
  );

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  // Stall the duty channel in random bursts, with calm stretches between
  initial begin
    forever begin
      @(negedge clk_i);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(10, 40)) @(negedge clk_i);
      end
    end
  end

  // Offer one tick, after a random gap, and hold it until the transfer
  task automatic send_tick(input int tgt, input int meas, input bit clr);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW - 2 * SpeedW){1'b0}}, SpeedW'(meas), SpeedW'(tgt)};
    s_axis_tuser  <= clr;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ticks_sent++;
    if (clr) clears_sent++;
  endtask

  // Drop the tick channel and hold until every duty has come back
  task automatic wait_for_duty_drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (duty_pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [LimitW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    reg_writes++;
  endtask

  task automatic load_setting(input int kp, input int ki, input int kd, input int ilim,
                              input int olim);
    wait_for_duty_drain();
    write_reg(REG_KP, LimitW'(kp));
    write_reg(REG_KI, LimitW'(ki));
    write_reg(REG_KD, LimitW'(kd));
    write_reg(REG_ILIM, LimitW'(ilim));
    write_reg(REG_OLIM, LimitW'(olim));
    settings_used++;
  endtask

  // Zero, the top of the range, or random bits (gain writes carry junk above)
  function automatic int pick_reg_value(input int top_val);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return top_val;
      2:       return $urandom_range(0, 255);
      default: return $urandom_range(0, LimitMax);
    endcase
  endfunction

  task automatic random_setting();
    load_setting(pick_reg_value(GainMax), pick_reg_value(GainMax),
                 pick_reg_value(GainMax), pick_reg_value(LimitMax),
                 pick_reg_value(LimitMax));
    if ($urandom_range(0, 1) == 0)
      write_reg(CfgIdxW'($urandom_range(int'(REG_OLIM) + 1, CfgIdxMax)),
                LimitW'($urandom_range(0, LimitMax)));
  endtask

  function automatic int clamp_speed(input int v);
    if (v > SpeedMax) return SpeedMax;
    if (v < SpeedMin) return SpeedMin;
    return v;
  endfunction

  // Mostly a smooth target with the measurement lagging behind, some noise
  task automatic run_ticks(input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 2) begin
        send_tick($urandom_range(0, LimitMax) % (1 << SpeedW) + SpeedMin,
                  $urandom_range(0, LimitMax) % (1 << SpeedW) + SpeedMin,
                  $urandom_range(0, 1));
      end else begin
        if ($urandom_range(0, 19) == 0) tgt_walk = $urandom_range(0, 8191) + SpeedMin;
        tgt_walk  = clamp_speed(tgt_walk + $urandom_range(0, 64) - 32);
        meas_walk = clamp_speed(meas_walk + (tgt_walk - meas_walk) / 4
                                + int'($urandom_range(0, 6)) - 3);
        send_tick(tgt_walk, meas_walk, $urandom_range(0, 15) == 0);
      end
      if (gaps_on && $urandom_range(0, 149) == 0) wait_for_duty_drain();
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset gains: full-scale errors both ways, clear, steady state
    send_tick(0, 0, 1'b0);
    send_tick(SpeedMax, SpeedMin, 1'b0);
    send_tick(SpeedMax, SpeedMin, 1'b0);
    send_tick(SpeedMin, SpeedMax, 1'b0);
    send_tick(SpeedMin, SpeedMax, 1'b1);
    send_tick(0, 0, 1'b0);
    send_tick(100, 90, 1'b0);
    send_tick(100, 100, 1'b0);
    send_tick(-1, 0, 1'b0);

    // Largest gains and limits: drive both accumulators into saturation
    load_setting(GainMax, GainMax, GainMax, LimitMax, LimitMax);
    send_tick(SpeedMax, SpeedMin, 1'b0);
    send_tick(SpeedMax, SpeedMin, 1'b0);
    send_tick(SpeedMin, SpeedMax, 1'b0);
    send_tick(SpeedMin, SpeedMax, 1'b0);
    send_tick(0, -1, 1'b1);

    // Zero limits force integral and duty to zero
    load_setting(GainMax, GainMax, GainMax, 0, 0);
    send_tick(SpeedMax, SpeedMin, 1'b0);
    send_tick(SpeedMin, SpeedMax, 1'b1);
    send_tick(1, 0, 1'b0);

    // Junk above the gain width, and writes to unused indexes
    wait_for_duty_drain();
    write_reg(REG_KP, LimitW'(LimitMax));
    write_reg(REG_OLIM, LimitW'(LimitMax));
    write_reg(CfgIdxW'(CfgIdxMax), LimitW'(LimitMax));
    write_reg(CfgIdxW'(int'(REG_OLIM) + 1), '0);
    send_tick(-1, SpeedMin, 1'b0);
    send_tick(SpeedMax, -1, 1'b0);

    // Random phases under changing settings; the last one without gaps
    for (int p = 0; p < Phases; p++) begin
      if (p == Phases - 1) gaps_on = 1'b0;
      random_setting();
      run_ticks(PhaseTicks);
    end

    wait_for_duty_drain();
    repeat (4 * OutputLatency) @(posedge clk_i);

    $display("Sent %0d ticks (%0d with integral clear) under %0d settings, %0d writes",
             ticks_sent, clears_sent, settings_used, reg_writes);
    $display("Checked %0d duty transfers, %0d still outstanding", duty_seen, duty_pending);
    if (mismatches == 0 && duty_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #TimeoutLimit;
    $display("Timed out with %0d duty results outstanding", duty_pending);
    $display("FAIL");
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/wsp_pkg.sv
src/wsp_cfg_regs.sv
src/wsp_pid_calc.sv
src/wheel_speed_pid.sv
tb/wsp_duty_checker.sv
tb/tb_top.sv
